FILE: sv/hhd_pkg.sv
package hhd_pkg;

    localparam int TBL_AW = 16;
    localparam int SYM_W  = 8;
    localparam int PAT_W  = 15;
    localparam int LEN_W  = 4;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    typedef logic [SYM_W:0] t_entry;

    typedef struct packed {
        logic clr_we;
        logic load_we;
        logic issue;
        logic resolve;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_stat;

endpackage

FILE: sv/hhd_ctrl.sv
module hhd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_req_type,
    input  hhd_pkg::t_stat i_stat,
    output hhd_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import hhd_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_LOOKUP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_req_type == REQ_LOAD) begin
                        o_cmd.load_we = 1'b1;
                    end else begin
                        o_cmd.issue = 1'b1;
                        n_state     = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                o_cmd.resolve = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: sv/hhd_datapath.sv
module hhd_datapath #(
    parameter int MAX_CODE_LEN = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hhd_pkg::t_cmd                 i_cmd,
    output hhd_pkg::t_stat                o_stat,
    input  logic [hhd_pkg::PAT_W-1:0]     i_code_pattern,
    input  logic [hhd_pkg::LEN_W-1:0]     i_code_length,
    input  logic [hhd_pkg::SYM_W-1:0]     i_symbol_value,
    input  logic                          i_bit_value,
    output logic [hhd_pkg::SYM_W-1:0]     o_decoded_symbol,
    output logic                          o_walk_error,
    output logic                          o_strobe
);
    import hhd_pkg::*;

    localparam int NODE_W = MAX_CODE_LEN + 1;
    localparam int DEP_W  = $clog2(MAX_CODE_LEN + 1);

    t_entry r_mem [2**TBL_AW];

    logic [TBL_AW-1:0] r_clr_addr;
    logic [NODE_W-1:0] r_node;
    logic [DEP_W-1:0]  r_depth;
    logic [NODE_W-1:0] r_next;
    logic [DEP_W-1:0]  r_next_depth;
    logic              r_beyond;
    t_entry            r_rd_data;
    logic [SYM_W-1:0]  r_sym;
    logic              r_err;
    logic              r_strobe;

    logic [NODE_W-1:0]        next_node;
    logic [NODE_W+TBL_AW-1:0] next_ext;
    logic [TBL_AW-1:0]        rd_addr;
    logic                     next_beyond;
    logic [TBL_AW-1:0]        load_bit;
    logic [TBL_AW-1:0]        load_idx;
    logic                     we;
    logic [TBL_AW-1:0]        wr_addr;
    t_entry                   wr_data;
    logic                     hit;
    logic                     deep;

    // child of the current node; anything at or above the table size reads empty
    assign next_node   = {r_node[NODE_W-2:0], i_bit_value};
    assign next_ext    = {{TBL_AW{1'b0}}, next_node};
    assign rd_addr     = next_ext[TBL_AW-1:0];
    assign next_beyond = |next_ext[NODE_W+TBL_AW-1:TBL_AW];

    assign load_bit = TBL_AW'(1) << i_code_length;
    assign load_idx = load_bit | ({1'b0, i_code_pattern} & (load_bit - TBL_AW'(1)));

    assign we      = i_cmd.clr_we | (i_cmd.load_we && (i_code_length != '0));
    assign wr_addr = i_cmd.clr_we ? r_clr_addr : load_idx;
    assign wr_data = i_cmd.clr_we ? t_entry'(0) : {1'b1, i_symbol_value};

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_stat.clr_last = (r_clr_addr == '1);

    assign hit  = r_rd_data[SYM_W] && !r_beyond;
    assign deep = (r_next_depth >= DEP_W'(MAX_CODE_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_node     <= NODE_W'(1);
            r_depth    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cmd.clr_we) begin
                r_clr_addr <= r_clr_addr + TBL_AW'(1);
            end
            r_strobe <= i_cmd.resolve && (hit || deep);
            if (i_cmd.resolve) begin
                if (hit || deep) begin
                    r_node  <= NODE_W'(1);
                    r_depth <= '0;
                end else begin
                    r_node  <= r_next;
                    r_depth <= r_next_depth;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_next       <= next_node;
            r_next_depth <= r_depth + DEP_W'(1);
            r_beyond     <= next_beyond;
        end
        if (i_cmd.resolve) begin
            r_sym <= hit ? r_rd_data[SYM_W-1:0] : '0;
            r_err <= !hit;
        end
    end

    assign o_decoded_symbol = r_sym;
    assign o_walk_error     = r_err;
    assign o_strobe         = r_strobe;

endmodule

FILE: sv/huffman_heap_tree_decoder.sv
// Huffman decoder walking a code tree held as a heap-ordered table
// (root at node 1, children of n at 2n and 2n+1).
// Input: a command is transferred on a rising edge with start high and busy
// low. i_req_type selects a table load (code pattern, length, symbol) or
// one decode bit (i_bit_value).
// Output: o_decoded_symbol / o_walk_error are valid for exactly one cycle
// while o_strobe is high; the receiver cannot stall, so it must take them.
// On a load, busy stays low and the next command may follow.
// A decode bit is done in order: the table read is registered, then the
// leaf / depth check runs. When a walk ends, o_strobe rises the cycle after
// the check, as busy drops again. No new command is taken until the check
// is done.
// Reset (synchronous, active low) returns the walk to the root and starts a
// clearing pass over the 65536-entry table, one entry per cycle; busy is
// high throughout the pass and no command is taken.
// A walk of MAX_CODE_LEN bits that finds no symbol reports o_walk_error.
module huffman_heap_tree_decoder #(
    parameter int MAX_CODE_LEN = 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_req_type,
    input  logic [hhd_pkg::PAT_W-1:0] i_code_pattern,
    input  logic [hhd_pkg::LEN_W-1:0] i_code_length,
    input  logic [hhd_pkg::SYM_W-1:0] i_symbol_value,
    input  logic                      i_bit_value,
    output logic [hhd_pkg::SYM_W-1:0] o_decoded_symbol,
    output logic                      o_walk_error,
    output logic                      o_strobe
);
    import hhd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    hhd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    hhd_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_code_pattern   (i_code_pattern),
        .i_code_length    (i_code_length),
        .i_symbol_value   (i_symbol_value),
        .i_bit_value      (i_bit_value),
        .o_decoded_symbol (o_decoded_symbol),
        .o_walk_error     (o_walk_error),
        .o_strobe         (o_strobe)
    );

    // a decode transfer always holds the block for its lookup cycle
    a_decode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req_type == REQ_DECODE) |=> busy)
        else $error("decode transfer did not enter lookup");

    // a load never blocks the next command
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req_type == REQ_LOAD) |=> !busy)
        else $error("load transfer left the block busy");

    // results only follow a lookup cycle
    a_strobe_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy) && !busy)
        else $error("result strobe outside a lookup");

    a_err_zero_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_walk_error |-> (o_decoded_symbol == '0))
        else $error("error result carries a symbol");

endmodule
